/* rtl/core/variable_record_ring_buffer_assert.svh */
// Assertion helpers for the record ring buffer.
`ifndef VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH
`define VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define VRRB_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vrrb: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define VRRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vrrb: next-cycle check failed");

`endif

/* rtl/core/vrrb_pkg.sv */
package vrrb_pkg;

    localparam int MEM_BYTES    = 4096;
    localparam int ADDR_W       = $clog2(MEM_BYTES);
    localparam int OFS_W        = 13;
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int HEADER_BYTES = 8;
    localparam int MAX_PAYLOAD  = 63;
    localparam int CAP_MIN      = 16;
    localparam int CAP_RESET    = (4096 < MEM_BYTES) ? 4096 : MEM_BYTES;

    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_POP     = 2'd2;
    localparam logic [1:0] CMD_PEEK    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BYTE   = 2'd3;

    typedef struct packed {
        logic              rec_we;
        logic [ADDR_W-1:0] rec_waddr;
        logic [BYTE_W-1:0] rec_wdata;
        logic [ADDR_W-1:0] rec_raddr;
        logic              tmp_we;
        logic [ADDR_W-1:0] tmp_waddr;
        logic [BYTE_W-1:0] tmp_wdata;
        logic [ADDR_W-1:0] tmp_raddr;
    } t_mem_req;

endpackage

/* rtl/core/vrrb_if.sv */
interface vrrb_in_if;
    import vrrb_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, command, length, data_byte, input ready);
    modport sink   (input valid, command, length, data_byte, output ready);
endinterface

interface vrrb_out_if;
    import vrrb_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [BYTE_W-1:0] data_byte_res;
    logic [LEN_W-1:0]  record_length;
    logic              last;
    modport source (output valid, status, data_byte_res, record_length, last, input ready);
    modport sink   (input valid, status, data_byte_res, record_length, last, output ready);
endinterface

/* rtl/core/vrrb_bytemem.sv */
module vrrb_bytemem (
    input  logic                              i_clk,
    input  vrrb_pkg::t_mem_req                i_req,
    output logic [vrrb_pkg::BYTE_W-1:0]       o_rec_rdata,
    output logic [vrrb_pkg::BYTE_W-1:0]       o_tmp_rdata
);
    import vrrb_pkg::*;

    // record store and rotation scratch, one write and one read port each
    logic [BYTE_W-1:0] rec_mem [MEM_BYTES];
    logic [BYTE_W-1:0] tmp_mem [MEM_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.rec_we) begin
            rec_mem[i_req.rec_waddr] <= i_req.rec_wdata;
        end
        o_rec_rdata <= rec_mem[i_req.rec_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.tmp_we) begin
            tmp_mem[i_req.tmp_waddr] <= i_req.tmp_wdata;
        end
        o_tmp_rdata <= tmp_mem[i_req.tmp_raddr];
    end

endmodule

/* rtl/core/variable_record_ring_buffer.sv */
// Ring buffer of variable-length records (8-byte header plus 0..63 payload bytes).
// Input channel i_in carries commands: reserve, write payload byte, pop, peek.
// Output channel o_out returns results; the last result of a command has last set.
// Reserve and write give one result; pop and peek give a header result and then
// one result per payload byte, or a single empty result.
// Reserve writes the header and zero fill (need = length + 8 bytes).
// Before that, the stored data may be compacted through the rotation scratch
// memory, the wrapped run included when the stored data wraps around the end.
// Pop and peek make one read of the record memory per result, whose data
// arrives in the next cycle.
// One command is in work at a time; i_in.ready is high only while idle and the
// output register is free. A stalled receiver holds the output register and
// the engine waits on it without losing data.
// Reset clears all offsets (buffer empty) and sets capacity to 4096. The memory
// needs no clearing pass: every byte read was written before.
// Write i_cfg_we/i_cfg_wdata only while idle; it clamps capacity and empties.
module variable_record_ring_buffer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    vrrb_in_if.sink                    i_in,
    vrrb_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [vrrb_pkg::OFS_W-1:0] i_cfg_wdata
);
    import vrrb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_COPY   = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;
    localparam logic [2:0] S_STREAM = 3'd6;

    localparam logic [1:0] PH_SEG_A = 2'd0;
    localparam logic [1:0] PH_SEG_B = 2'd1;
    localparam logic [1:0] PH_BACK  = 2'd2;

    localparam logic [OFS_W-1:0] HDR  = OFS_W'(HEADER_BYTES);

    logic [2:0]        r_state, n_state;
    logic [OFS_W-1:0]  r_cap, n_cap;
    logic [OFS_W-1:0]  r_head, n_head;
    logic [OFS_W-1:0]  r_tail, n_tail;
    logic [OFS_W-1:0]  r_wrap, n_wrap;
    logic [OFS_W-1:0]  r_wofs, n_wofs;
    logic [LEN_W-1:0]  r_btw, n_btw;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_adv, n_adv;
    logic [OFS_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        r_phase, n_phase;
    logic [OFS_W-1:0]  r_seg_a, n_seg_a;
    logic [OFS_W-1:0]  r_seg_b, n_seg_b;
    logic              r_pw_valid, n_pw_valid;
    logic [ADDR_W-1:0] r_pw_addr, n_pw_addr;
    logic              r_pw_tmp, n_pw_tmp;
    logic [OFS_W-1:0]  r_place, n_place;
    logic [1:0]        r_resp, n_resp;
    logic              r_inflight, n_inflight;
    logic [LEN_W-1:0]  r_slen, n_slen;

    logic              r_o_valid, n_o_valid;
    logic [1:0]        r_o_status, n_o_status;
    logic [BYTE_W-1:0] r_o_data, n_o_data;
    logic [LEN_W-1:0]  r_o_len, n_o_len;
    logic              r_o_last, n_o_last;

    t_mem_req          mem_req;
    logic [BYTE_W-1:0] rec_rdata;
    logic [BYTE_W-1:0] tmp_rdata;

    logic              out_free;
    logic              accept;
    logic [OFS_W-1:0]  used;
    logic [OFS_W-1:0]  need;
    logic [OFS_W-1:0]  cp_count, cp_src, cp_dst;
    logic [OFS_W:0]    tail_need;
    logic [LEN_W-1:0]  adv_len;
    logic [OFS_W-1:0]  adv_head;
    logic              str_last;

    vrrb_bytemem u_mem (
        .i_clk       (i_clk),
        .i_req       (mem_req),
        .o_rec_rdata (rec_rdata),
        .o_tmp_rdata (tmp_rdata)
    );

    assign out_free       = !r_o_valid || o_out.ready;
    assign i_in.ready     = (r_state == S_IDLE) && out_free;
    assign accept         = i_in.valid && i_in.ready;

    assign o_out.valid         = r_o_valid;
    assign o_out.status        = r_o_status;
    assign o_out.data_byte_res = r_o_data;
    assign o_out.record_length = r_o_len;
    assign o_out.last          = r_o_last;

    // bytes held between head and tail, counting the wrapped run
    assign used      = (r_tail >= r_head) ? (r_tail - r_head) : (r_wrap - r_head + r_tail);
    assign need      = OFS_W'(r_len) + HDR;
    assign tail_need = {1'b0, r_tail} + {1'b0, need};

    // compaction runs in three phases: older run to scratch, wrapped run after
    // it, then the whole block back to the start of the record memory
    always_comb begin
        unique case (r_phase)
            PH_SEG_A: begin
                cp_count = r_seg_a;
                cp_src   = r_head;
                cp_dst   = '0;
            end
            PH_SEG_B: begin
                cp_count = r_seg_b;
                cp_src   = '0;
                cp_dst   = r_seg_a;
            end
            default: begin
                cp_count = r_seg_a + r_seg_b;
                cp_src   = '0;
                cp_dst   = '0;
            end
        endcase
    end

    // streaming: header length comes from the memory on the first result
    assign adv_len  = (r_cnt == '0) ? rec_rdata[LEN_W-1:0] : r_slen;
    assign adv_head = r_head + HDR + OFS_W'(adv_len);
    assign str_last = (r_cnt == '0) ? (rec_rdata[LEN_W-1:0] == '0)
                                    : (r_cnt == OFS_W'(r_slen));

    always_comb begin
        n_state    = r_state;
        n_cap      = r_cap;
        n_head     = r_head;
        n_tail     = r_tail;
        n_wrap     = r_wrap;
        n_wofs     = r_wofs;
        n_btw      = r_btw;
        n_len      = r_len;
        n_adv      = r_adv;
        n_cnt      = r_cnt;
        n_phase    = r_phase;
        n_seg_a    = r_seg_a;
        n_seg_b    = r_seg_b;
        n_pw_valid = 1'b0;
        n_pw_addr  = r_pw_addr;
        n_pw_tmp   = r_pw_tmp;
        n_place    = r_place;
        n_resp     = r_resp;
        n_inflight = r_inflight;
        n_slen     = r_slen;
        n_o_valid  = r_o_valid && !o_out.ready;
        n_o_status = r_o_status;
        n_o_data   = r_o_data;
        n_o_len    = r_o_len;
        n_o_last   = r_o_last;

        mem_req           = '0;
        mem_req.rec_raddr = r_head[ADDR_W-1:0];

        // land the copy read issued last cycle
        if (r_pw_valid) begin
            if (r_pw_tmp) begin
                mem_req.tmp_we    = 1'b1;
                mem_req.tmp_waddr = r_pw_addr;
                mem_req.tmp_wdata = rec_rdata;
            end else begin
                mem_req.rec_we    = 1'b1;
                mem_req.rec_waddr = r_pw_addr;
                mem_req.rec_wdata = tmp_rdata;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // every single-result command answers with last set
                    n_o_data = '0;
                    n_o_len  = '0;
                    n_o_last = 1'b1;
                    unique case (i_in.command)
                        CMD_RESERVE: begin
                            // a new reserve ends writes to the previous record
                            n_btw = '0;
                            if (OFS_W'(i_in.length) > OFS_W'(MAX_PAYLOAD)) begin
                                n_o_valid  = 1'b1;
                                n_o_status = ST_NOROOM;
                            end else begin
                                n_len   = i_in.length;
                                n_state = S_DECIDE;
                            end
                        end
                        CMD_WRITE: begin
                            n_o_valid = 1'b1;
                            if (r_btw == '0) begin
                                n_o_status = ST_NOROOM;
                            end else begin
                                mem_req.rec_we    = 1'b1;
                                mem_req.rec_waddr = r_wofs[ADDR_W-1:0];
                                mem_req.rec_wdata = i_in.data_byte;
                                n_wofs     = r_wofs + OFS_W'(1);
                                n_btw      = r_btw - LEN_W'(1);
                                n_o_status = ST_OK;
                            end
                        end
                        default: begin
                            if (r_head == r_tail) begin
                                n_o_valid  = 1'b1;
                                n_o_status = ST_EMPTY;
                            end else begin
                                n_adv      = (i_in.command == CMD_POP);
                                n_cnt      = '0;
                                n_inflight = 1'b0;
                                n_state    = S_STREAM;
                            end
                        end
                    endcase
                end
            end

            S_DECIDE: begin
                // compact first when little is stored
                if ((used <= need) && (used <= (r_cap >> 1)) && (r_head != '0)) begin
                    if (used == '0) begin
                        n_head  = '0;
                        n_state = S_PLACE;
                    end else begin
                        n_seg_a = (r_tail >= r_head) ? (r_tail - r_head) : (r_wrap - r_head);
                        n_seg_b = (r_tail >= r_head) ? '0 : r_tail;
                        n_phase = PH_SEG_A;
                        n_cnt   = '0;
                        n_state = S_COPY;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_COPY: begin
                if (r_cnt != cp_count) begin
                    // one byte a cycle: read now, write on the next cycle
                    if (r_phase == PH_BACK) begin
                        mem_req.tmp_raddr = ADDR_W'(cp_src + r_cnt);
                    end else begin
                        mem_req.rec_raddr = ADDR_W'(cp_src + r_cnt);
                    end
                    n_pw_valid = 1'b1;
                    n_pw_addr  = ADDR_W'(cp_dst + r_cnt);
                    n_pw_tmp   = (r_phase != PH_BACK);
                    n_cnt      = r_cnt + OFS_W'(1);
                end else if (!r_pw_valid) begin
                    // drain the last write before the next phase reads
                    n_cnt = '0;
                    if (r_phase == PH_BACK) begin
                        n_head  = '0;
                        n_tail  = r_seg_a + r_seg_b;
                        n_wrap  = r_seg_a + r_seg_b;
                        n_state = S_PLACE;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end

            S_PLACE: begin
                n_cnt   = '0;
                n_state = S_FILL;
                if (r_tail >= r_head) begin
                    if ({1'b0, r_cap} >= tail_need) begin
                        n_place = r_tail;
                        n_tail  = tail_need[OFS_W-1:0];
                        n_wrap  = tail_need[OFS_W-1:0];
                    end else if (r_head > need) begin
                        // waste the gap before the end and restart at zero
                        n_wrap  = r_tail;
                        n_place = '0;
                        n_tail  = need;
                    end else begin
                        n_resp  = ST_NOROOM;
                        n_state = S_RESP;
                    end
                end else if ({1'b0, r_head} > tail_need) begin
                    n_place = r_tail;
                    n_tail  = tail_need[OFS_W-1:0];
                end else begin
                    n_resp  = ST_NOROOM;
                    n_state = S_RESP;
                end
            end

            S_FILL: begin
                // header byte 0 holds the length, the rest goes to zero
                mem_req.rec_we    = 1'b1;
                mem_req.rec_waddr = ADDR_W'(r_place + r_cnt);
                mem_req.rec_wdata = (r_cnt == '0) ? BYTE_W'(r_len) : '0;
                n_cnt             = r_cnt + OFS_W'(1);
                if (r_cnt == need - OFS_W'(1)) begin
                    n_wofs  = r_place + HDR;
                    n_btw   = r_len;
                    n_resp  = ST_OK;
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_resp;
                    n_o_data   = '0;
                    n_o_len    = '0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            S_STREAM: begin
                if (r_inflight) begin
                    n_inflight = 1'b0;
                    n_o_valid  = 1'b1;
                    n_o_last   = str_last;
                    n_cnt      = r_cnt + OFS_W'(1);
                    if (r_cnt == '0) begin
                        n_o_status = ST_OK;
                        n_o_data   = '0;
                        n_o_len    = rec_rdata[LEN_W-1:0];
                        n_slen     = rec_rdata[LEN_W-1:0];
                    end else begin
                        n_o_status = ST_BYTE;
                        n_o_data   = rec_rdata;
                        n_o_len    = '0;
                    end
                    if (str_last) begin
                        n_state = S_IDLE;
                        if (r_adv) begin
                            if (adv_head == r_tail) begin
                                n_head = '0;
                                n_tail = '0;
                                n_wrap = '0;
                                n_wofs = '0;
                                n_btw  = '0;
                            end else if (adv_head >= r_wrap) begin
                                n_head = '0;
                                n_wrap = r_tail;
                            end else begin
                                n_head = adv_head;
                            end
                        end
                    end
                end else if (out_free) begin
                    mem_req.rec_raddr = (r_cnt == '0) ? r_head[ADDR_W-1:0]
                                        : ADDR_W'(r_head + HDR + r_cnt - OFS_W'(1));
                    n_inflight = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // capacity write: clamp and empty the buffer
        if (i_cfg_we) begin
            priority if (i_cfg_wdata > OFS_W'(MEM_BYTES)) begin
                n_cap = OFS_W'(MEM_BYTES);
            end else if (i_cfg_wdata < OFS_W'(CAP_MIN)) begin
                n_cap = OFS_W'(CAP_MIN);
            end else begin
                n_cap = i_cfg_wdata;
            end
            n_head = '0;
            n_tail = '0;
            n_wrap = '0;
            n_wofs = '0;
            n_btw  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cap      <= OFS_W'(CAP_RESET);
            r_head     <= '0;
            r_tail     <= '0;
            r_wrap     <= '0;
            r_wofs     <= '0;
            r_btw      <= '0;
            r_pw_valid <= 1'b0;
            r_inflight <= 1'b0;
            r_o_valid  <= 1'b0;
            r_cnt      <= '0;
            r_phase    <= PH_SEG_A;
        end else begin
            r_state    <= n_state;
            r_cap      <= n_cap;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_wrap     <= n_wrap;
            r_wofs     <= n_wofs;
            r_btw      <= n_btw;
            r_pw_valid <= n_pw_valid;
            r_inflight <= n_inflight;
            r_o_valid  <= n_o_valid;
            r_cnt      <= n_cnt;
            r_phase    <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_adv      <= n_adv;
        r_seg_a    <= n_seg_a;
        r_seg_b    <= n_seg_b;
        r_pw_addr  <= n_pw_addr;
        r_pw_tmp   <= n_pw_tmp;
        r_place    <= n_place;
        r_resp     <= n_resp;
        r_slen     <= n_slen;
        r_o_status <= n_o_status;
        r_o_data   <= n_o_data;
        r_o_len    <= n_o_len;
        r_o_last   <= n_o_last;
    end

`include "variable_record_ring_buffer_assert.svh"

    // offsets stay inside the configured capacity
    `VRRB_ASSERT_IMPLY(a_head_in_cap, 1'b1, r_head <= r_cap)
    `VRRB_ASSERT_IMPLY(a_tail_in_cap, 1'b1, r_tail <= r_cap)
    // copy writes land only while compaction runs
    `VRRB_ASSERT_IMPLY(a_copy_write_in_copy, r_pw_valid, r_state == S_COPY)
    // a stream read returns into a free output register
    `VRRB_ASSERT_IMPLY(a_stream_slot_free, r_inflight, !r_o_valid)

endmodule

/* verif/vrrb_scoreboard.sv */
`timescale 1ns / 100ps

module vrrb_scoreboard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    vrrb_in_if.sink                    i_cmd,
    vrrb_out_if.sink                   i_res,
    input  logic                       i_cfg_we,
    input  logic [vrrb_pkg::OFS_W-1:0] i_cfg_wdata,
    output int                         o_errors,
    output int                         o_pending
);
    import vrrb_pkg::*;

    typedef struct {
        logic [1:0]        status;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  rec_len;
        logic              last;
    } t_result;

    t_result expected_results[$];

    logic [BYTE_W-1:0] rec_mem [0:MEM_BYTES-1];
    logic [BYTE_W-1:0] rot_mem [0:MEM_BYTES-1];
    int unsigned cap, head, tail, wrap_end, wr_ofs, wr_left;

    assign o_pending = expected_results.size();

    initial begin
        o_errors = 0;
    end

    function automatic int unsigned wrap_at(int unsigned idx);
        return idx % MEM_BYTES;
    endfunction

    function automatic int unsigned stored_bytes();
        if (tail >= head) return tail - head;
        return (wrap_end - head) + tail;
    endfunction

    task automatic push_result(logic [1:0] st, logic [7:0] d, logic [5:0] l, logic lst);
        t_result r;
        r.status = st; r.data = d; r.rec_len = l; r.last = lst;
        expected_results.push_back(r);
    endtask

    task automatic clear_offsets();
        head = 0; tail = 0; wrap_end = 0; wr_ofs = 0; wr_left = 0;
    endtask

    // Move stored records to the start of memory, keeping record order.
    function automatic void compact_records();
        int unsigned a, b;
        if (head == 0) return;
        if (stored_bytes() > 0) begin
            if (tail >= head) begin
                a = tail - head;
                for (int unsigned i = 0; i < a; i++)
                    rec_mem[wrap_at(i)] = rec_mem[wrap_at(head + i)];
                tail = a; wrap_end = a;
            end else begin
                a = wrap_end - head;
                b = tail;
                for (int unsigned i = 0; i < a; i++)
                    rot_mem[wrap_at(i)] = rec_mem[wrap_at(head + i)];
                for (int unsigned i = 0; i < b; i++)
                    rot_mem[wrap_at(a + i)] = rec_mem[wrap_at(i)];
                for (int unsigned i = 0; i < a + b; i++)
                    rec_mem[wrap_at(i)] = rot_mem[wrap_at(i)];
                tail = a + b; wrap_end = a + b;
            end
        end
        head = 0;
    endfunction

    function automatic logic [1:0] place_record(int unsigned len);
        int unsigned need, place;
        bit ok;
        ok = 0;
        wr_left = 0;
        if (len > MAX_PAYLOAD) return ST_NOROOM;
        need = len + HEADER_BYTES;
        if (stored_bytes() <= need && stored_bytes() <= cap / 2) compact_records();
        place = tail;
        if (tail >= head) begin
            if (cap - tail >= need) begin
                tail += need; wrap_end = tail; ok = 1;
            end else if (head >= 1 && head - 1 >= need) begin
                wrap_end = tail; place = 0; tail = need; ok = 1;
            end
        end else if (head - tail - 1 >= need) begin
            tail += need; ok = 1;
        end
        if (!ok) return ST_NOROOM;
        rec_mem[wrap_at(place)] = len[7:0];
        for (int unsigned i = 1; i < need; i++) rec_mem[wrap_at(place + i)] = '0;
        wr_ofs = place + HEADER_BYTES;
        wr_left = len;
        return ST_OK;
    endfunction

    task automatic stream_head_record(bit advance);
        int unsigned len;
        if (head == tail) begin
            push_result(ST_EMPTY, '0, '0, 1'b1);
            return;
        end
        len = rec_mem[wrap_at(head)] & 8'h3F;
        push_result(ST_OK, '0, len[5:0], len == 0);
        for (int unsigned i = 0; i < len; i++)
            push_result(ST_BYTE, rec_mem[wrap_at(head + HEADER_BYTES + i)], '0, i + 1 == len);
        if (advance) begin
            head += HEADER_BYTES + len;
            if (head == tail) clear_offsets();
            else if (head >= wrap_end) begin
                head = 0; wrap_end = tail;
            end
        end
    endtask

    task automatic report(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cap = CAP_RESET;
            clear_offsets();
        end else begin
            if (i_cfg_we) begin
                cap = 32'(i_cfg_wdata);
                if (cap > MEM_BYTES) cap = MEM_BYTES;
                if (cap < CAP_MIN) cap = CAP_MIN;
                clear_offsets();
            end
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.command)
                    CMD_RESERVE: push_result(place_record(32'(i_cmd.length)), '0, '0, 1'b1);
                    CMD_WRITE: begin
                        if (wr_left == 0) push_result(ST_NOROOM, '0, '0, 1'b1);
                        else begin
                            rec_mem[wrap_at(wr_ofs)] = i_cmd.data_byte;
                            wr_ofs++; wr_left--;
                            push_result(ST_OK, '0, '0, 1'b1);
                        end
                    end
                    CMD_POP:  stream_head_record(1'b1);
                    default:  stream_head_record(1'b0);
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    report("extra result status", 32'(i_res.status), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.status !== want.status) report("status", i_res.status, want.status);
                    if (i_res.data_byte_res !== want.data)
                        report("data_byte_res", i_res.data_byte_res, want.data);
                    if (i_res.record_length !== want.rec_len)
                        report("record_length", i_res.record_length, want.rec_len);
                    if (i_res.last !== want.last) report("last", i_res.last, want.last);
                end
            end
        end
    end

endmodule

/* verif/variable_record_ring_buffer_test.sv */
`timescale 1ns / 100ps

module variable_record_ring_buffer_test;
    import vrrb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [OFS_W-1:0] cfg_wdata = '0;
    logic cmd_fire = 1'b0;
    int errors, pending;
    int hold_cycles = 0;     // long receiver hold-off request
    bit sender_steady = 0;   // no idling on either side while set

    vrrb_in_if  cmd_ch ();
    vrrb_out_if res_ch ();

    variable_record_ring_buffer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_ch.sink),
        .o_out       (res_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    vrrb_scoreboard checker_u (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch.sink),
        .i_res       (res_ch.sink),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    // Capture the transfer at the edge so the sender sees it without a race.
    always @(posedge i_clk) cmd_fire <= cmd_ch.valid && cmd_ch.ready;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_RESERVE;
        cmd_ch.length = '0;
        cmd_ch.data_byte = '0;
        res_ch.ready = 1'b0;
    end

    // Receiver: random stalls, a steady stretch, and a long hold-off on request.
    initial begin
        int held;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                held = hold_cycles;
                hold_cycles = 0;
            end
            if (held > 0) begin
                res_ch.ready = 1'b0;
                held--;
            end else if (sender_steady) begin
                res_ch.ready = 1'b1;
            end else begin
                res_ch.ready = $urandom_range(99) >= 36;
            end
        end
    end

    // Offer one command; valid stays high into the next command when no gap follows.
    task automatic send_cmd(logic [1:0] cmd, logic [5:0] len, logic [7:0] db);
        if (!sender_steady) begin
            while ($urandom_range(99) < 36) begin
                cmd_ch.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.command = cmd;
        cmd_ch.length = len;
        cmd_ch.data_byte = db;
        do @(negedge i_clk); while (!cmd_fire);
    endtask

    task automatic drain_and_idle();
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_capacity(logic [OFS_W-1:0] value);
        drain_and_idle();
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        @(negedge i_clk);
    endtask

    // Reserve a record, then write all or part of its payload.
    task automatic record_sequence(int max_len);
        int len, n;
        len = ($urandom_range(9) == 0) ? max_len : $urandom_range(max_len < 12 ? max_len : 12);
        send_cmd(CMD_RESERVE, len[5:0], 8'($urandom));
        n = ($urandom_range(4) == 0) ? $urandom_range(len) : len;
        for (int i = 0; i < n; i++) send_cmd(CMD_WRITE, 6'($urandom), 8'($urandom));
    endtask

    task automatic random_traffic(int items, int max_len);
        int r;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            if (r < 45) record_sequence(max_len);
            else if (r < 70) send_cmd(CMD_POP, 6'($urandom), 8'($urandom));
            else if (r < 85) send_cmd(CMD_PEEK, 6'($urandom), 8'($urandom));
            else send_cmd(2'($urandom), 6'($urandom), 8'($urandom));    // noise
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty buffer, write without a record, extremes of length and data.
        send_cmd(CMD_POP, 6'h3F, 8'hFF);
        send_cmd(CMD_PEEK, 6'h00, 8'h00);
        send_cmd(CMD_WRITE, 6'h00, 8'hA5);
        send_cmd(CMD_RESERVE, 6'd0, 8'h00);
        send_cmd(CMD_PEEK, 6'd0, 8'h00);
        send_cmd(CMD_POP, 6'd0, 8'h00);
        send_cmd(CMD_RESERVE, 6'd63, 8'hFF);
        send_cmd(CMD_WRITE, 6'h3F, 8'hFF);
        send_cmd(CMD_WRITE, 6'h00, 8'h00);
        send_cmd(CMD_WRITE, 6'h15, 8'h5A);
        // A new reserve ends the unfinished payload; the rest reads as zero.
        send_cmd(CMD_RESERVE, 6'd2, 8'h00);
        send_cmd(CMD_WRITE, 6'h00, 8'h81);
        send_cmd(CMD_WRITE, 6'h00, 8'h7E);
        send_cmd(CMD_WRITE, 6'h00, 8'h11);
        send_cmd(CMD_PEEK, 6'd0, 8'h00);
        send_cmd(CMD_POP, 6'd0, 8'h00);
        send_cmd(CMD_POP, 6'd0, 8'h00);
        send_cmd(CMD_POP, 6'd0, 8'h00);

        // Smallest capacity: one record fits, the next finds no room.
        set_capacity(13'd0);
        send_cmd(CMD_RESERVE, 6'd8, 8'h00);
        send_cmd(CMD_RESERVE, 6'd0, 8'h00);
        send_cmd(CMD_POP, 6'd0, 8'h00);
        random_traffic(2, 8);

        // Mid capacity forces wrap and compaction; hold the receiver off to fill up.
        set_capacity(13'd100);
        random_traffic(8, 63);
        hold_cycles = 400;
        random_traffic(3, 20);

        // Above the memory size clamps to the full memory.
        set_capacity(13'h1FFF);
        sender_steady = 1;
        random_traffic(3, 63);
        sender_steady = 0;
        random_traffic(2, 63);

        set_capacity(13'd200);
        random_traffic(3, 40);

        drain_and_idle();
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* variable_record_ring_buffer.f */
+incdir+rtl/core
rtl/core/vrrb_pkg.sv
rtl/core/vrrb_if.sv
rtl/core/vrrb_bytemem.sv
rtl/core/variable_record_ring_buffer.sv
verif/vrrb_scoreboard.sv
verif/variable_record_ring_buffer_test.sv
